// ===== rtl/irl_pkg.sv =====
package irl_pkg;

    localparam int TS_W    = 32;
    localparam int CFG_W   = 16;
    localparam int USED_W  = 16;
    localparam int MISS_W  = 32;
    localparam int PROD_W  = 2 * USED_W;
    localparam int QUO_W   = USED_W;
    localparam int CNT_W   = $clog2(QUO_W);
    localparam int CIDX_W  = 1;

    localparam logic [MISS_W-1:0] MISS_MAX = '1;

    typedef enum logic [CIDX_W-1:0] {
        CFG_INTERVAL = 1'b0,
        CFG_BURST    = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_START,
        ST_DIV_WAIT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== rtl/irl_div.sv =====
module irl_div
    import irl_pkg::*;
#(
    parameter int DVSR_W = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_req          i_req,
    input  logic [DVSR_W-1:0] i_divisor,
    output t_div_rsp          o_rsp
);

    // Restoring division, one quotient bit per cycle. The caller guarantees
    // the quotient fits QUO_W bits, so the upper dividend half seeds the
    // remainder directly.
    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DVSR_W-1:0] r_rem;
    logic [QUO_W-1:0]  r_quo;

    logic [DVSR_W:0]   w_trial;
    logic [DVSR_W:0]   w_diff;
    logic              w_qbit;
    logic [DVSR_W-1:0] n_rem;

    always_comb begin
        w_trial = {r_rem, r_quo[QUO_W-1]};
        w_diff  = w_trial - {1'b0, i_divisor};
        w_qbit  = ~w_diff[DVSR_W];
        n_rem   = w_qbit ? w_diff[DVSR_W-1:0] : w_trial[DVSR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QUO_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= DVSR_W'(i_req.dividend[PROD_W-1:QUO_W]);
            r_quo <= i_req.dividend[QUO_W-1:0];
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[QUO_W-2:0], w_qbit};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== rtl/interval_burst_rate_limiter.sv =====
// Interval/burst rate limiter, one request at a time through a single divider.
// A request is accepted in IDLE and finished in PREP; when the used count
// decays, PREP first passes START and DIV_WAIT (16-step radix-2 divider).
// Requests stall while one is in flight; a stalled result holds the next.
// Reset (synchronous, active low): counts and reference time clear to zero,
// interval to 1, burst limit to 0; no clearing pass is needed.
module interval_burst_rate_limiter
    import irl_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [TS_W-1:0]   i_timestamp,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_allowed,
    output logic [USED_W-1:0] o_used_count,
    output logic [MISS_W-1:0] o_missed_count,
    // configuration write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers. Always ready; writes land only while idle
    // by contract of use.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] r_interval;
    logic [CFG_W-1:0] r_burst;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= CFG_W'(1);
            r_burst    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_INTERVAL: r_interval <= i_cfg_data;
                CFG_BURST:    r_burst    <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // Treat a zero interval as one tick.
    logic [CFG_W-1:0]      w_ivl;
    logic [TIME_WIDTH-1:0] w_ivl_t;

    assign w_ivl   = (r_interval == '0) ? CFG_W'(1) : r_interval;
    assign w_ivl_t = TIME_WIDTH'(w_ivl);

    // ------------------------------------------------------------------
    // Limiter state and per-request working registers
    // ------------------------------------------------------------------
    t_state                r_state;
    t_state                n_state;
    logic [USED_W-1:0]     r_used;
    logic [MISS_W-1:0]     r_missed;
    logic [TIME_WIDTH-1:0] r_ref;
    logic [TIME_WIDTH-1:0] r_now;
    logic [TIME_WIDTH-1:0] r_elapsed;
    logic [PROD_W-1:0]     r_prod;
    logic                  r_scaled;

    logic [TIME_WIDTH-1:0] w_elapsed;
    logic                  w_decay;
    logic                  w_out_free;
    logic                  w_ok;

    t_div_req              w_div_req;
    t_div_rsp              w_div_rsp;

    // Control decoded from state
    logic                  c_accept;
    logic                  c_prep;
    logic                  c_finish;

    // Decay is due when now is at or past the reference time, at least
    // one interval has gone by, and this request has not been scaled yet.
    assign w_elapsed = r_now - r_ref;
    assign w_decay   = !r_scaled && (r_now >= r_ref) && (w_elapsed >= w_ivl_t);

    // The output register frees when empty or when its result is taken.
    assign w_out_free = !o_out_valid || !i_out_stall;

    // Admit while the used count is below the burst limit.
    assign w_ok = r_used < r_burst;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                // No decay: finish directly once the result slot frees.
                if (w_decay) begin
                    n_state = ST_START;
                end else if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_START: begin
                n_state = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (w_div_rsp.done) begin
                    n_state = ST_PREP;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer. After the divider hands back the scaled
    // count, the sequencer re-enters PREP; by then the reference time has
    // moved to now - interval, so elapsed equals interval... which would
    // decay again. A flag marks the second pass to skip the decay check.
    always_comb begin
        c_accept           = 1'b0;
        c_prep             = 1'b0;
        c_finish           = 1'b0;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = r_prod;
        unique case (r_state)
            ST_IDLE: begin
                c_accept = i_in_valid;
            end
            ST_PREP: begin
                c_prep   = w_decay;
                c_finish = !w_decay && w_out_free;
            end
            ST_START: begin
                w_div_req.start = 1'b1;
            end
            ST_DIV_WAIT: ;
            default: ;
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

    // Sequencer and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_missed    <= '0;
            r_ref       <= '0;
            r_scaled    <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (c_finish) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            if (c_accept) begin
                r_scaled <= 1'b0;
            end
            if (c_prep) begin
                // Move the reference to now - interval; scale after divide.
                r_ref    <= r_now - w_ivl_t;
                r_scaled <= 1'b1;
            end
            if (r_state == ST_DIV_WAIT && w_div_rsp.done) begin
                r_used <= w_div_rsp.quotient;
            end
            if (c_finish) begin
                if (w_ok) begin
                    r_used <= r_used + 1'b1;
                end else if (r_missed != MISS_MAX) begin
                    r_missed <= r_missed + 1'b1;
                end
            end
        end
    end

    // Working payload registers
    always_ff @(posedge i_clk) begin
        if (c_accept) begin
            r_now <= TIME_WIDTH'(i_timestamp);
        end
        if (c_prep) begin
            r_elapsed <= w_elapsed;
            r_prod    <= r_used * w_ivl;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (c_finish) begin
            o_allowed      <= w_ok;
            o_used_count   <= w_ok ? (r_used + 1'b1) : r_used;
            o_missed_count <= (!w_ok && (r_missed != MISS_MAX)) ?
                              (r_missed + 1'b1) : r_missed;
        end
    end

    irl_div #(
        .DVSR_W (TIME_WIDTH)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_div_req),
        .i_divisor (r_elapsed),
        .o_rsp     (w_div_rsp)
    );

endmodule

// ===== test/tb.sv =====
module tb;
    import irl_pkg::*;

    localparam int HOLD_LEN  = 300;    // long receiver hold-off, in cycles
    localparam int TAIL_WAIT = 25;     // a bit above the slowest request (decay path)
    localparam int WATCHDOG  = 3000;   // cycles without any handshake before giving up
    localparam int PLAN_LEN  = 24;
    localparam int FILL_TOP  = 40;     // burst limit for the fill run

    // One result as the block reports it
    typedef struct packed {
        logic              allowed;
        logic [USED_W-1:0] used;
        logic [MISS_W-1:0] missed;
    } verdict_t;

    typedef enum bit {
        ROW_REQ,
        ROW_CFG
    } row_kind_e;

    // One row of the directed sequence: either a register write or a request.
    // Requests with typed set carry their expected verdict; the others are
    // checked against the predictor, which every request advances.
    typedef struct packed {
        row_kind_e         kind;
        t_cfg_reg          reg_sel;
        logic [TS_W-1:0]   value;
        bit                typed;
        verdict_t          want;
    } plan_row_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [TS_W-1:0]   i_timestamp;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_allowed;
    logic [USED_W-1:0] o_used_count;
    logic [MISS_W-1:0] o_missed_count;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CIDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_data;

    interval_burst_rate_limiter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_timestamp    (i_timestamp),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_allowed      (o_allowed),
        .o_used_count   (o_used_count),
        .o_missed_count (o_missed_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Predictor state: mirrors the limiter's counters, reference time and
    // registers, updated at every accepted request or register write.
    logic [USED_W-1:0] lim_used     = '0;
    logic [MISS_W-1:0] lim_missed   = '0;
    logic [TS_W-1:0]   lim_ref      = '0;
    logic [CFG_W-1:0]  lim_interval = 16'd1;
    logic [CFG_W-1:0]  lim_burst    = 16'd0;

    verdict_t verdict_q[$];   // expected verdicts, oldest first
    int       mismatches = 0;
    int       stall_cycles = 0;

    // Hold-off requests from the stimulus side, served by the receiver process
    int       hold_reqs = 0;
    int       hold_done = 0;
    bit       idle_in_on  = 1'b1;
    bit       idle_out_on = 1'b1;

    logic [TS_W-1:0] cur_ts = '0;   // running request time

    // Directed sequence. Reset leaves interval 1 and burst 0, so every request
    // is denied until the burst limit is raised. Interval 0 must act as 1;
    // requests timed below the reference time must not decay the used count.
    plan_row_t plan [PLAN_LEN] = '{
        '{ROW_REQ, CFG_INTERVAL, 32'd0,      1'b1, '{1'b0, 16'd0, 32'd1}},
        '{ROW_REQ, CFG_INTERVAL, 32'd0,      1'b1, '{1'b0, 16'd0, 32'd2}},
        '{ROW_CFG, CFG_INTERVAL, 32'd0,      1'b0, '0},
        '{ROW_CFG, CFG_BURST,    32'd2,      1'b0, '0},
        '{ROW_REQ, CFG_INTERVAL, 32'd1,      1'b1, '{1'b1, 16'd1, 32'd2}},
        '{ROW_REQ, CFG_INTERVAL, 32'd1,      1'b1, '{1'b1, 16'd2, 32'd2}},
        '{ROW_REQ, CFG_INTERVAL, 32'd1,      1'b1, '{1'b0, 16'd2, 32'd3}},
        '{ROW_REQ, CFG_INTERVAL, 32'd3,      1'b0, '0},
        '{ROW_REQ, CFG_INTERVAL, 32'd0,      1'b0, '0},
        '{ROW_CFG, CFG_INTERVAL, 32'd65535,  1'b0, '0},
        '{ROW_CFG, CFG_BURST,    32'd65535,  1'b0, '0},
        '{ROW_REQ, CFG_INTERVAL, 32'd100,    1'b1, '{1'b1, 16'd3, 32'd3}},
        '{ROW_REQ, CFG_INTERVAL, 32'd200000, 1'b0, '0},
        '{ROW_CFG, CFG_BURST,    32'd0,      1'b0, '0},
        '{ROW_REQ, CFG_INTERVAL, 32'd200000, 1'b0, '0},
        '{ROW_CFG, CFG_INTERVAL, 32'd7,      1'b0, '0},
        '{ROW_CFG, CFG_BURST,    32'd5,      1'b0, '0},
        '{ROW_REQ, CFG_INTERVAL, 32'd200010, 1'b0, '0},
        '{ROW_REQ, CFG_INTERVAL, 32'd200010, 1'b0, '0},
        '{ROW_REQ, CFG_INTERVAL, 32'd200012, 1'b0, '0},
        '{ROW_REQ, CFG_INTERVAL, 32'd200030, 1'b0, '0},
        '{ROW_REQ, CFG_INTERVAL, 32'd200030, 1'b0, '0},
        '{ROW_REQ, CFG_INTERVAL, 32'd200100, 1'b0, '0},
        '{ROW_REQ, CFG_INTERVAL, 32'd150,    1'b0, '0}
    };

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string line);
        $display("tb: mismatch at %0t: %s", $realtime, line);
        mismatches++;
    endtask

    // Advance the limiter state by one request and return its verdict.
    function automatic verdict_t limiter_predict(input logic [TS_W-1:0] ts);
        logic [CFG_W-1:0] ivl;
        logic [TS_W-1:0]  elapsed;
        logic [31:0]      scaled;
        verdict_t         v;
        ivl = (lim_interval == '0) ? 16'd1 : lim_interval;
        if (ts >= lim_ref) begin
            elapsed = ts - lim_ref;
            if (elapsed >= 32'(ivl)) begin
                scaled   = 32'(lim_used) * 32'(ivl);
                lim_used = USED_W'(scaled / elapsed);
                lim_ref  = ts - 32'(ivl);
            end
        end
        v.allowed = (lim_used < lim_burst);
        if (v.allowed) begin
            lim_used = lim_used + 1'b1;
        end else if (lim_missed != MISS_MAX) begin
            lim_missed = lim_missed + 1'b1;
        end
        v.used   = lim_used;
        v.missed = lim_missed;
        return v;
    endfunction

    // Offer one request, idling first at random, and hold it until accepted.
    task automatic send_req(input logic [TS_W-1:0] ts, input bit typed, input verdict_t want);
        verdict_t guess;
        i_cfg_valid <= 1'b0;
        while (idle_in_on && $urandom_range(99) < 30) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_timestamp <= ts;
        do @(posedge i_clk); while (o_in_stall);
        guess = limiter_predict(ts);
        verdict_q.push_back(typed ? want : guess);
    endtask

    // Stop offering and wait until every pending verdict has come back.
    task automatic flush_pending();
        i_in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
    endtask

    // Write one register; valid stays up so back-to-back writes need no gap.
    task automatic write_reg(input t_cfg_reg sel, input logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (sel == CFG_INTERVAL) begin
            lim_interval = val;
        end else begin
            lim_burst = val;
        end
    endtask

    // One random phase: fresh registers, then a run of requests whose times
    // mostly move forward around the interval, with some stragglers timed
    // below the reference time.
    task automatic run_phase(input int n_items, input bit with_hold);
        logic [CFG_W-1:0] ivl_v;
        logic [CFG_W-1:0] burst_v;
        logic [TS_W-1:0]  ts;
        int unsigned      span;
        int               pick;
        case ($urandom_range(9))
            0: ivl_v = 16'd0;
            1: ivl_v = 16'hFFFF;
            2: ivl_v = 16'($urandom_range(65535));
            default: ivl_v = 16'($urandom_range(64, 1));
        endcase
        case ($urandom_range(9))
            0: burst_v = 16'd0;
            1: burst_v = 16'hFFFF;
            2: burst_v = 16'($urandom_range(65535));
            default: burst_v = 16'($urandom_range(12, 1));
        endcase
        flush_pending();
        write_reg(CFG_INTERVAL, ivl_v);
        write_reg(CFG_BURST, burst_v);
        for (int i = 0; i < n_items; i++) begin
            // receiver goes quiet while requests keep coming, to back up the block
            if (with_hold && i == n_items / 3) hold_reqs++;
            pick = $urandom_range(99);
            if (pick < 10) begin
                ts = (lim_ref == '0) ? '0 : TS_W'($urandom_range(lim_ref - 1));
            end else begin
                if (pick < 25) begin
                    span = 0;
                end else if (pick < 90) begin
                    span = 2 * ((ivl_v == '0) ? 1 : int'(ivl_v));
                end else begin
                    span = 1 << 20;
                end
                cur_ts = cur_ts + TS_W'($urandom_range(span));
                ts = cur_ts;
            end
            send_req(ts, 1'b0, '0);
        end
    endtask

    // Receiver: random stalls, or a long counted hold-off when one is requested
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_done != hold_reqs) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_LEN - 1) @(posedge i_clk);
                hold_done++;
            end else begin
                i_out_stall <= idle_out_on && ($urandom_range(99) < 30);
            end
        end
    end

    // Check every delivered result against the oldest expectation
    always @(posedge i_clk) begin
        verdict_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (verdict_q.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending (allowed %0b used %0d)",
                                          o_allowed, o_used_count));
            end else begin
                want = verdict_q.pop_front();
                if (o_allowed !== want.allowed)
                    report_mismatch($sformatf("allowed %b, want %b", o_allowed, want.allowed));
                if (o_used_count !== want.used)
                    report_mismatch($sformatf("used_count %0d, want %0d",
                                              o_used_count, want.used));
                if (o_missed_count !== want.missed)
                    report_mismatch($sformatf("missed_count %0d, want %0d",
                                              o_missed_count, want.missed));
            end
        end
    end

    // Watchdog: any handshake on any channel counts as progress
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG) begin
            $display("tb: watchdog expired at %0t", $realtime);
            $display("tb: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Stimulus
    initial begin
        logic [TS_W-1:0] ts;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_timestamp = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows
        foreach (plan[k]) begin
            if (plan[k].kind == ROW_CFG) begin
                flush_pending();
                write_reg(plan[k].reg_sel, plan[k].value[CFG_W-1:0]);
            end else begin
                send_req(plan[k].value, plan[k].typed, plan[k].want);
            end
        end
        cur_ts = 32'd200100;

        // Fill the used count up to the burst limit with no idling: requests
        // at the reference time never decay, and the last one is denied.
        idle_in_on  = 1'b0;
        idle_out_on = 1'b0;
        flush_pending();
        write_reg(CFG_INTERVAL, 16'hFFFF);
        write_reg(CFG_BURST, 16'(FILL_TOP));
        while (lim_used < 16'(FILL_TOP)) send_req(lim_ref, 1'b0, '0);
        send_req(lim_ref, 1'b0, '0);
        // elapsed equal to the interval keeps the count, then a longer gap scales it
        send_req(lim_ref + 32'd65535, 1'b0, '0);
        ts = lim_ref + 32'd100000;
        send_req(ts, 1'b0, '0);
        if (ts > cur_ts) cur_ts = ts;
        idle_in_on  = 1'b1;
        idle_out_on = 1'b1;

        // random phases; one runs with no idling, one with a long hold-off
        for (int p = 0; p < 8; p++) begin
            idle_in_on  = (p != 2);
            idle_out_on = (p != 2);
            run_phase(70, p == 5);
        end

        // late times up to the top of the time range
        flush_pending();
        write_reg(CFG_INTERVAL, 16'($urandom_range(65535, 1)));
        write_reg(CFG_BURST, 16'($urandom_range(12, 1)));
        cur_ts = 32'h8000_0000 + TS_W'($urandom_range(32'h3FFF_FFFF));
        for (int i = 0; i < 8; i++) begin
            cur_ts = cur_ts + TS_W'($urandom_range(1 << 20));
            send_req(cur_ts, 1'b0, '0);
        end
        send_req(32'hFFFF_FFFF, 1'b0, '0);
        send_req(32'hFFFF_FFFF, 1'b0, '0);

        // drain, then watch a little longer for stray results
        flush_pending();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (verdict_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", verdict_q.size()));
        if (mismatches == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
